>>> design/wvsf_pkg.sv
// ----------------------------------------------------------------------------
// wvsf_pkg
// Shared types and constants for the windowed vertical speed fit block.
// ----------------------------------------------------------------------------
`default_nettype none

package wvsf_pkg;

	// Field widths of the data and configuration ports.
	localparam int HEIGHT_W = 24;
	localparam int TIME_W   = 32;
	localparam int VEL_W    = 21;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 2;

	// Velocity is reported in mm/s from a slope in mm/us.
	localparam int VEL_SCALE = 1000000;
	localparam int VEL_LIMIT = 1000000;

	// Operation codes of the input channel.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPAN   = 2'd1;

	// Status reported by the multi-cycle arithmetic units.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage : wvsf_pkg

`default_nettype wire

>>> design/wvsf_mul.sv
// ----------------------------------------------------------------------------
// wvsf_mul
// Shift-and-add multiplier: signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle, finishing as soon as no set bits remain.
// ----------------------------------------------------------------------------
`default_nettype none

module wvsf_mul #(
	parameter int AW = 102,
	parameter int BW = 70
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic signed [AW-1:0]   a,
	input  wire logic        [BW-1:0]   b,
	output wvsf_pkg::unit_stat_t        stat,
	output logic signed      [AW-1:0]   product
);
	import wvsf_pkg::*;

	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] a_q;
	logic        [BW-1:0] b_q;
	logic                 busy_q;
	logic                 done_q;

	// Control: run until the remaining multiplier bits are all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (b_q == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: one conditional add of the shifted multiplicand per cycle.
	// The true product fits in AW bits, so bits shifted out never matter.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = acc_q;

endmodule : wvsf_mul

`default_nettype wire

>>> design/wvsf_div.sv
// ----------------------------------------------------------------------------
// wvsf_div
// Restoring divider: signed numerator over a positive denominator, one
// quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module wvsf_div #(
	parameter int W = 102
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic signed [W-1:0]   num,
	input  wire logic        [W-1:0]   den,
	output wvsf_pkg::unit_stat_t       stat,
	output logic signed      [W-1:0]   quotient
);
	import wvsf_pkg::*;

	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     mag_q;
	logic [W:0]       rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     den_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W:0]       rem_sh;
	logic             fits;

	// Trial subtraction of the next partial remainder.
	assign rem_sh = {rem_q[W-1:0], mag_q[W-1]};
	assign fits   = (rem_sh >= {1'b0, den_q});

	// Control: one quotient bit per cycle over all W numerator bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath on the magnitude of the numerator.
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num[W-1] ? W'(-num) : W'(num);
			neg_q <= num[W-1];
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			mag_q <= mag_q << 1;
			if (fits) begin
				rem_q <= rem_sh - {1'b0, den_q};
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule : wvsf_div

`default_nettype wire

>>> design/windowed_vertical_speed_fit.sv
// A repeated height is dropped and a clear empties the window; neither gives
// a result. A stored sample first trims stale entries one at a time; when at
// least two entries cover the minimum span, it sums them and runs up to seven
// sequential products and two divisions of PW = 90 + 2*clog2(WINDOW_DEPTH + 1)
// bits, then loads its result once the output register is free. One item is
// in flight at a time; reset empties the window, no clearing pass.
// ----------------------------------------------------------------------------
// windowed_vertical_speed_fit
// Sliding-window least-squares fit of height against time, giving a fitted
// height, vertical speed and running peak height.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_vertical_speed_fit #(
	parameter int WINDOW_DEPTH = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// Input channel
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic                                   op,
	input  wire logic signed [wvsf_pkg::HEIGHT_W-1:0]   height_mm,
	input  wire logic        [wvsf_pkg::TIME_W-1:0]     time_us,
	// Output channel
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed      [wvsf_pkg::HEIGHT_W-1:0]   est_height_mm,
	output logic signed      [wvsf_pkg::VEL_W-1:0]      velocity_mm_s,
	output logic                                        fit_valid,
	output logic signed      [wvsf_pkg::HEIGHT_W-1:0]   max_height_mm,
	// Configuration channel
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic        [wvsf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic        [wvsf_pkg::CFG_W-1:0]      cfg_data
);
	import wvsf_pkg::*;

	// Derived widths.
	localparam int IW    = $clog2(WINDOW_DEPTH);
	localparam int CW    = $clog2(WINDOW_DEPTH + 1);
	localparam int SU_W  = TIME_W + CW;
	localparam int SUU_W = 2 * TIME_W + CW;
	localparam int SH_W  = HEIGHT_W + CW;
	localparam int UH_W  = TIME_W + HEIGHT_W + 1;
	localparam int SUH_W = UH_W + CW;
	localparam int PW    = 90 + 2 * CW;
	localparam int BW    = SUU_W;
	localparam int MW    = TIME_W + HEIGHT_W;

	localparam logic [IW-1:0] LAST_SLOT = IW'(WINDOW_DEPTH - 1);
	localparam logic [IW:0]   DEPTH_X   = (IW + 1)'(WINDOW_DEPTH);
	localparam logic [CW-1:0] DEPTH_C   = CW'(WINDOW_DEPTH);
	localparam logic [CW-1:0] MIN_KEEP  = CW'(2);

	localparam logic signed [PW-1:0] VEL_MAX = VEL_LIMIT;
	localparam logic signed [PW-1:0] VEL_MIN = -VEL_LIMIT;
	localparam logic signed [PW-1:0] EST_MAX = (1 <<< (HEIGHT_W - 1)) - 1;
	localparam logic signed [PW-1:0] EST_MIN = -(1 <<< (HEIGHT_W - 1));

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_TRIM_RD  = 9'b000000010,
		S_TRIM_CK  = 9'b000000100,
		S_ACC      = 9'b000001000,
		S_MUL_GO   = 9'b000010000,
		S_MUL_WAIT = 9'b000100000,
		S_DIV_GO   = 9'b001000000,
		S_DIV_WAIT = 9'b010000000,
		S_OUT      = 9'b100000000
	} state_t;

	// Order of the products that make up the fit.
	typedef enum logic [2:0] {
		MS_N_SUU,
		MS_SU_SU,
		MS_SU_SH,
		MS_N_SUH,
		MS_SCALE,
		MS_SH_SUU,
		MS_SU_SUH
	} mstep_t;

	state_t state_q;
	mstep_t mstep_q;

	// Configuration and window bookkeeping.
	logic [CFG_W-1:0]           wlen_q;
	logic [CFG_W-1:0]           min_span_q;
	logic [IW-1:0]              oldest_q;
	logic [CW-1:0]              held_q;
	logic signed [HEIGHT_W-1:0] prev_h_q;
	logic                       seen_q;
	logic signed [HEIGHT_W-1:0] peak_q;
	logic signed [HEIGHT_W-1:0] h_q;
	logic [TIME_W-1:0]          now_q;

	// Sample memory.
	logic [MW-1:0]              mem [WINDOW_DEPTH];
	logic [MW-1:0]              rd_data_q;
	logic                       rd_en;
	logic [IW-1:0]              rd_addr;
	logic                       wr_en;
	logic [IW-1:0]              wr_addr;
	logic [IW:0]                slot_sum;

	// Accumulation pipeline.
	logic [IW-1:0]              acc_ptr_q;
	logic [CW-1:0]              acc_cnt_q;
	logic                       v_s1_q, v_s2_q, v_s3_q;
	logic [TIME_W-1:0]          u_s2, u_s3;
	logic signed [HEIGHT_W-1:0] h_s2, h_s3;
	logic [2*TIME_W-1:0]        uu_s3;
	logic signed [UH_W-1:0]     uh_s3;
	logic [SU_W-1:0]            su_q;
	logic [SUU_W-1:0]           suu_q;
	logic signed [SH_W-1:0]     sh_q;
	logic signed [SUH_W-1:0]    suh_q;
	logic                       acc_issue;

	// Fit arithmetic.
	logic signed [PW-1:0]       t0_q, t1_q, nv_q, na_q, d_q;
	logic signed [PW-1:0]       mul_a;
	logic        [BW-1:0]       mul_b;
	logic signed [PW-1:0]       mul_p;
	logic signed [PW-1:0]       diff;
	unit_stat_t                 mul_stat;
	unit_stat_t                 div_stat;
	logic signed [PW-1:0]       div_q;
	logic                       div_sel_q;
	logic signed [VEL_W-1:0]    vel_q;
	logic signed [HEIGHT_W-1:0] est_fit_q;
	logic                       fit_q;
	logic signed [PW-1:0]       vel_clamp;
	logic signed [PW-1:0]       est_clamp;

	// Output register.
	logic                       out_valid_q;
	logic signed [HEIGHT_W-1:0] est_out_q;
	logic signed [VEL_W-1:0]    vel_out_q;
	logic                       fit_out_q;
	logic signed [HEIGHT_W-1:0] peak_out_q;
	logic signed [HEIGHT_W-1:0] est_sel;
	logic signed [HEIGHT_W-1:0] peak_next;

	logic in_xfer, is_sample, is_repeat, out_load;
	logic [TIME_W-1:0] age;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign is_sample = (op == OP_SAMPLE);
	assign is_repeat = seen_q && (height_mm == prev_h_q);
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// Configuration register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q     <= CFG_W'(1000000);
			min_span_q <= CFG_W'(200000);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WINDOW_LEN: wlen_q     <= cfg_data;
				REG_MIN_SPAN:   min_span_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// Slot for a new sample: the oldest one when the ring is full.
	assign slot_sum = (IW + 1)'(oldest_q) + (IW + 1)'(held_q);
	always_comb begin
		if (held_q == DEPTH_C) begin
			wr_addr = oldest_q;
		end else if (slot_sum >= DEPTH_X) begin
			wr_addr = IW'(slot_sum - DEPTH_X);
		end else begin
			wr_addr = IW'(slot_sum);
		end
	end
	assign wr_en = in_xfer && is_sample && !is_repeat;

	// Memory read port is shared by the trim check and the accumulation.
	assign acc_issue = (state_q == S_ACC) && (acc_cnt_q != held_q);
	assign rd_en     = (state_q == S_TRIM_RD) || acc_issue;
	assign rd_addr   = (state_q == S_ACC) ? acc_ptr_q : oldest_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {time_us, height_mm};
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign age = now_q - rd_data_q[MW-1:HEIGHT_W];

	// Per-entry terms: age, then the products, then the running sums.
	always_ff @(posedge clk) begin
		u_s2  <= now_q - rd_data_q[MW-1:HEIGHT_W];
		h_s2  <= rd_data_q[HEIGHT_W-1:0];
		u_s3  <= u_s2;
		h_s3  <= h_s2;
		uu_s3 <= u_s2 * u_s2;
		uh_s3 <= $signed({1'b0, u_s2}) * h_s2;
	end

	// Product operand selection for each step of the fit.
	always_comb begin
		case (mstep_q)
			MS_N_SUU:  begin mul_a = PW'(suu_q);  mul_b = BW'(held_q); end
			MS_SU_SU:  begin mul_a = PW'(su_q);   mul_b = BW'(su_q);   end
			MS_SU_SH:  begin mul_a = PW'(sh_q);   mul_b = BW'(su_q);   end
			MS_N_SUH:  begin mul_a = PW'(suh_q);  mul_b = BW'(held_q); end
			MS_SCALE:  begin mul_a = t1_q;        mul_b = BW'(VEL_SCALE); end
			MS_SH_SUU: begin mul_a = PW'(sh_q);   mul_b = suu_q;       end
			MS_SU_SUH: begin mul_a = PW'(suh_q);  mul_b = BW'(su_q);   end
			default:   begin mul_a = '0;          mul_b = '0;          end
		endcase
	end
	assign diff = t0_q - mul_p;

	wvsf_mul #(.AW(PW), .BW(BW)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_MUL_GO),
		.a       (mul_a),
		.b       (mul_b),
		.stat    (mul_stat),
		.product (mul_p)
	);

	wvsf_div #(.W(PW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_DIV_GO),
		.num      (div_sel_q ? na_q : nv_q),
		.den      (d_q),
		.stat     (div_stat),
		.quotient (div_q)
	);

	// Saturation of the two quotients.
	always_comb begin
		if (div_q > VEL_MAX) begin
			vel_clamp = VEL_MAX;
		end else if (div_q < VEL_MIN) begin
			vel_clamp = VEL_MIN;
		end else begin
			vel_clamp = div_q;
		end
		if (div_q > EST_MAX) begin
			est_clamp = EST_MAX;
		end else if (div_q < EST_MIN) begin
			est_clamp = EST_MIN;
		end else begin
			est_clamp = div_q;
		end
	end

	// Fit datapath registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			h_q   <= height_mm;
			now_q <= time_us;
		end
		if ((state_q == S_TRIM_CK) && !((held_q > MIN_KEEP) && (age > TIME_W'(wlen_q)))) begin
			su_q  <= '0;
			suu_q <= '0;
			sh_q  <= '0;
			suh_q <= '0;
		end else if (v_s3_q) begin
			su_q  <= su_q + SU_W'(u_s3);
			suu_q <= suu_q + SUU_W'(uu_s3);
			sh_q  <= sh_q + SH_W'(h_s3);
			suh_q <= suh_q + SUH_W'(uh_s3);
		end
		if ((state_q == S_MUL_WAIT) && mul_stat.done) begin
			case (mstep_q)
				MS_N_SUU:  t0_q <= mul_p;
				MS_SU_SU:  d_q  <= diff;
				MS_SU_SH:  t0_q <= mul_p;
				MS_N_SUH:  t1_q <= diff;
				MS_SCALE:  nv_q <= mul_p;
				MS_SH_SUU: t0_q <= mul_p;
				MS_SU_SUH: na_q <= diff;
				default:   ;
			endcase
		end
		if ((state_q == S_DIV_WAIT) && div_stat.done) begin
			if (div_sel_q) begin
				est_fit_q <= est_clamp[HEIGHT_W-1:0];
			end else begin
				vel_q <= vel_clamp[VEL_W-1:0];
			end
		end
	end

	// Result selection and peak tracking.
	assign est_sel   = fit_q ? est_fit_q : h_q;
	assign peak_next = (est_sel > peak_q) ? est_sel : peak_q;

	always_ff @(posedge clk) begin
		if (out_load) begin
			est_out_q  <= est_sel;
			vel_out_q  <= fit_q ? vel_q : '0;
			fit_out_q  <= fit_q;
			peak_out_q <= peak_next;
		end
	end

	// Sequencer and window state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mstep_q     <= MS_N_SUU;
			oldest_q    <= '0;
			held_q      <= '0;
			prev_h_q    <= '0;
			seen_q      <= 1'b0;
			peak_q      <= '0;
			acc_ptr_q   <= '0;
			acc_cnt_q   <= '0;
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			v_s3_q      <= 1'b0;
			div_sel_q   <= 1'b0;
			fit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1_q <= acc_issue;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q;
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (!is_sample) begin
							oldest_q <= '0;
							held_q   <= '0;
							prev_h_q <= '0;
							seen_q   <= 1'b0;
							peak_q   <= '0;
						end else if (!is_repeat) begin
							seen_q   <= 1'b1;
							prev_h_q <= height_mm;
							fit_q    <= 1'b0;
							if (held_q == DEPTH_C) begin
								oldest_q <= (oldest_q == LAST_SLOT) ? '0 : oldest_q + 1'b1;
							end else begin
								held_q <= held_q + 1'b1;
							end
							state_q <= S_TRIM_RD;
						end
					end
				end
				S_TRIM_RD: begin
					state_q <= S_TRIM_CK;
				end
				S_TRIM_CK: begin
					// Drop stale entries one at a time, keeping two.
					if ((held_q > MIN_KEEP) && (age > TIME_W'(wlen_q))) begin
						oldest_q <= (oldest_q == LAST_SLOT) ? '0 : oldest_q + 1'b1;
						held_q   <= held_q - 1'b1;
						state_q  <= S_TRIM_RD;
					end else if ((held_q >= MIN_KEEP) && (age >= TIME_W'(min_span_q))) begin
						acc_ptr_q <= oldest_q;
						acc_cnt_q <= '0;
						state_q   <= S_ACC;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_ACC: begin
					if (acc_issue) begin
						acc_ptr_q <= (acc_ptr_q == LAST_SLOT) ? '0 : acc_ptr_q + 1'b1;
						acc_cnt_q <= acc_cnt_q + 1'b1;
					end else if (!v_s1_q && !v_s2_q && !v_s3_q) begin
						mstep_q <= MS_N_SUU;
						state_q <= S_MUL_GO;
					end
				end
				S_MUL_GO: begin
					state_q <= S_MUL_WAIT;
				end
				S_MUL_WAIT: begin
					if (mul_stat.done) begin
						case (mstep_q)
							MS_N_SUU: begin
								mstep_q <= MS_SU_SU;
								state_q <= S_MUL_GO;
							end
							MS_SU_SU: begin
								// A zero denominator means no usable spread in time.
								if (diff[PW-1] || (diff == '0)) begin
									state_q <= S_OUT;
								end else begin
									mstep_q <= MS_SU_SH;
									state_q <= S_MUL_GO;
								end
							end
							MS_SU_SH: begin
								mstep_q <= MS_N_SUH;
								state_q <= S_MUL_GO;
							end
							MS_N_SUH: begin
								mstep_q <= MS_SCALE;
								state_q <= S_MUL_GO;
							end
							MS_SCALE: begin
								mstep_q <= MS_SH_SUU;
								state_q <= S_MUL_GO;
							end
							MS_SH_SUU: begin
								mstep_q <= MS_SU_SUH;
								state_q <= S_MUL_GO;
							end
							MS_SU_SUH: begin
								div_sel_q <= 1'b0;
								state_q   <= S_DIV_GO;
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_stat.done) begin
						if (div_sel_q) begin
							fit_q   <= 1'b1;
							state_q <= S_OUT;
						end else begin
							div_sel_q <= 1'b1;
							state_q   <= S_DIV_GO;
						end
					end
				end
				S_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						peak_q      <= peak_next;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign est_height_mm = est_out_q;
	assign velocity_mm_s = vel_out_q;
	assign fit_valid     = fit_out_q;
	assign max_height_mm = peak_out_q;

	// The window never holds more entries than the ring has slots.
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= DEPTH_C)
		else $error("window count exceeds ring depth");

	// The two arithmetic units are never busy at the same time.
	a_units_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_stat.busy && div_stat.busy))
		else $error("multiplier and divider overlap");

	// A fit is only summed over at least two entries.
	a_acc_two: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC) |-> (held_q >= MIN_KEEP))
		else $error("accumulation with fewer than two entries");

	// A result is loaded only when the output register is free or drains.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

endmodule : windowed_vertical_speed_fit

`default_nettype wire

>>> sim/windowed_vertical_speed_fit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_vertical_speed_fit_test
// Self-checking bench for the windowed vertical speed fit. A behavioral model
// keeps its own sample ring and computes the least-squares fit with exact
// 128-bit arithmetic. Each result transfer is checked against the oldest
// expected fit. Stimulus is a directed part followed by climb and descent
// profiles with noise, under several window settings and random idling.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_vertical_speed_fit_test;
	import wvsf_pkg::*;

	localparam int DEPTH = 32;
	localparam int DRAIN_CYCLES = 2500;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic signed [HEIGHT_W-1:0] est;
		logic signed [VEL_W-1:0]    vel;
		logic                       fit;
		logic signed [HEIGHT_W-1:0] peak;
	} fit_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic op = OP_SAMPLE;
	logic signed [HEIGHT_W-1:0] height_mm = '0;
	logic [TIME_W-1:0] time_us = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [HEIGHT_W-1:0] est_height_mm;
	logic signed [VEL_W-1:0] velocity_mm_s;
	logic fit_valid;
	logic signed [HEIGHT_W-1:0] max_height_mm;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	windowed_vertical_speed_fit #(.WINDOW_DEPTH(DEPTH)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op),
		.height_mm(height_mm), .time_us(time_us),
		.out_valid(out_valid), .out_ready(out_ready),
		.est_height_mm(est_height_mm), .velocity_mm_s(velocity_mm_s),
		.fit_valid(fit_valid), .max_height_mm(max_height_mm),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Model state: sample ring, window bookkeeping and registers.
	logic signed [HEIGHT_W-1:0] ring_height [DEPTH];
	logic [TIME_W-1:0] ring_time [DEPTH];
	logic [4:0] oldest;
	int unsigned held;
	logic signed [HEIGHT_W-1:0] last_height;
	bit have_sample;
	logic signed [HEIGHT_W-1:0] peak;
	logic [CFG_W-1:0] window_len;
	logic [CFG_W-1:0] min_span;

	fit_result_t pending_fits[$];
	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	int hold_request = 0;
	int mismatches = 0;
	int fits_checked = 0;
	int fits_with_line = 0;
	int items_sent = 0;
	logic [TIME_W-1:0] clock_us = 32'd5000;

	function automatic logic signed [127:0] clamp(logic signed [127:0] v,
			logic signed [127:0] lo, logic signed [127:0] hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Window update and least-squares fit for one stored sample.
	task automatic fit_window(input logic signed [HEIGHT_W-1:0] h, input logic [TIME_W-1:0] t);
		logic [4:0] slot, newest, k;
		logic [TIME_W-1:0] span, u;
		logic signed [127:0] su, sh, suu, suh, n, uw, hw, d, nv, na, est, vel;
		fit_result_t r;
		bit line;
		line = 0;
		if (held >= DEPTH) begin
			oldest = oldest + 5'd1;
			held = DEPTH - 1;
		end
		slot = oldest + 5'(held);
		ring_height[slot] = h;
		ring_time[slot] = t;
		held++;
		while (held > 2 && (t - ring_time[oldest]) > {8'd0, window_len}) begin
			oldest = oldest + 5'd1;
			held--;
		end
		newest = oldest + 5'(held - 1);
		span = ring_time[newest] - ring_time[oldest];
		est = ring_height[newest];
		vel = 0;
		if (held >= 2 && span >= {8'd0, min_span}) begin
			su = 0; sh = 0; suu = 0; suh = 0;
			n = held;
			for (int i = 0; i < held; i++) begin
				k = oldest + 5'(i);
				u = ring_time[newest] - ring_time[k];
				uw = u;
				hw = ring_height[k];
				su += uw;
				sh += hw;
				suu += uw * uw;
				suh += uw * hw;
			end
			d = n * suu - su * su;
			if (d > 0) begin
				nv = (su * sh - n * suh) * 1000000;
				na = sh * suu - su * suh;
				vel = clamp(nv / d, -VEL_LIMIT, VEL_LIMIT);
				est = clamp(na / d, -8388608, 8388607);
				line = 1;
			end
		end
		if (est > peak) peak = est[HEIGHT_W-1:0];
		r.est = est[HEIGHT_W-1:0];
		r.vel = vel[VEL_W-1:0];
		r.fit = line;
		r.peak = peak;
		pending_fits.push_back(r);
	endtask

	task automatic model_clear();
		oldest = '0;
		held = 0;
		last_height = '0;
		have_sample = 0;
		peak = '0;
	endtask

	task automatic model_item(input logic o, input logic signed [HEIGHT_W-1:0] h,
			input logic [TIME_W-1:0] t);
		if (o == OP_CLEAR) begin
			model_clear();
		end else if (!(have_sample && h == last_height)) begin
			have_sample = 1;
			last_height = h;
			fit_window(h, t);
		end
	endtask

	// Offer one item, idling first at the sender's rate.
	task automatic send_item(input logic o, input logic signed [HEIGHT_W-1:0] h,
			input logic [TIME_W-1:0] t);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		height_mm <= h;
		time_us <= t;
		do @(posedge clk); while (!in_ready);
		model_item(o, h, t);
		items_sent++;
	endtask

	task automatic sample_at(input logic signed [HEIGHT_W-1:0] h, input int unsigned dt);
		clock_us = clock_us + dt;
		send_item(OP_SAMPLE, h, clock_us);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_fits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register writes happen only with the block idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_WINDOW_LEN) window_len = val;
		else if (idx == REG_MIN_SPAN) min_span = val;
	endtask

	task automatic set_window(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] span);
		drain();
		write_reg(REG_WINDOW_LEN, len);
		write_reg(REG_MIN_SPAN, span);
	endtask

	// Climb or descent with noise; a small noise range also yields repeats.
	task automatic flight_profile(input int count, input int step_lo, input int step_hi);
		int base, rate, noise;
		base = $urandom_range(20000) - 10000;
		rate = $urandom_range(400) - 200;
		noise = $urandom_range(6);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 3)
				send_item(OP_CLEAR, HEIGHT_W'($urandom), $urandom);
			else if ($urandom_range(99) < 5)
				send_item(OP_SAMPLE, HEIGHT_W'($urandom), $urandom);
			else
				sample_at(HEIGHT_W'(base + rate * i + $urandom_range(2 * noise) - noise),
					$urandom_range(step_hi, step_lo));
		end
	endtask

	task automatic test_directed();
		send_item(OP_CLEAR, 24'sd0, 32'd0);
		// The first sample of zero is not a repeat of the reset height.
		sample_at(24'sd0, 0);
		sample_at(24'sd0, 100000);
		sample_at(24'sd8388607, 100000);
		sample_at(-24'sd8388608, 300000);
		sample_at(24'sd1000, 300000);
		// Two more samples share the last timestamp.
		send_item(OP_SAMPLE, 24'sd5, clock_us);
		send_item(OP_SAMPLE, 24'sd6, clock_us);
		send_item(OP_CLEAR, 24'sd0, 32'hFFFF_FFFF);
		// Timestamps that wrap and run backwards.
		send_item(OP_SAMPLE, 24'sd10, 32'hFFFF_0000);
		send_item(OP_SAMPLE, 24'sd20, 32'h0002_0000);
		send_item(OP_SAMPLE, 24'sd30, 32'h0001_0000);
		send_item(OP_SAMPLE, 24'sd40, 32'h0004_0000);
		drain();
		// Huge slope over one microsecond saturates velocity.
		write_reg(REG_MIN_SPAN, 24'd0);
		write_reg(REG_SPARE, 24'hFFFFFF);
		send_item(OP_CLEAR, 24'sd0, 32'd0);
		send_item(OP_SAMPLE, -24'sd8388608, 32'd100);
		send_item(OP_SAMPLE, 24'sd8388607, 32'd101);
		// Extrapolation beyond the height range saturates the estimate.
		send_item(OP_SAMPLE, -24'sd8388608, 32'd102);
		send_item(OP_SAMPLE, 24'sd8388607, 32'd110);
		send_item(OP_SAMPLE, 24'sd8000000, 32'd200);
		send_item(OP_SAMPLE, 24'sd8000000, 32'd300);
	endtask

	task automatic test_settings();
		set_window(24'd1, 24'd0);
		flight_profile(60, 0, 3);
		set_window(24'hFFFFFF, 24'hFFFFFF);
		flight_profile(60, 100000, 2000000);
		set_window(24'd500000, 24'd50000);
		flight_profile(90, 1000, 60000);
		set_window(24'd1000000, 24'd200000);
		flight_profile(90, 10000, 100000);
	endtask

	task automatic test_backpressure();
		drain();
		hold_request = 3000;
		flight_profile(20, 10000, 50000);
		drain();
		flight_profile(40, 1000, 100000);
	endtask

	task automatic test_idle_mix();
		sender_idle_pct = 15;
		receiver_idle_pct = 76;
		flight_profile(90, 5000, 80000);
		sender_idle_pct = 76;
		receiver_idle_pct = 15;
		flight_profile(90, 5000, 80000);
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		flight_profile(90, 5000, 80000);
	endtask

	// Result side: random stalls plus a long hold-off on request.
	always @(posedge clk) begin
		if (hold_request > 0) begin
			out_ready <= 1'b0;
			hold_request <= hold_request - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Compare each result transfer with the oldest expected fit.
	always @(posedge clk) begin
		fit_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_fits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result est=%0d vel=%0d fit=%0b peak=%0d",
						est_height_mm, velocity_mm_s, fit_valid, max_height_mm);
			end else begin
				want = pending_fits.pop_front();
				fits_checked++;
				if (want.fit) fits_with_line++;
				if (est_height_mm !== want.est || velocity_mm_s !== want.vel ||
						fit_valid !== want.fit || max_height_mm !== want.peak) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: result %0d expected est=%0d vel=%0d fit=%0b peak=%0d, got est=%0d vel=%0d fit=%0b peak=%0d",
							fits_checked, want.est, want.vel, want.fit, want.peak,
							est_height_mm, velocity_mm_s, fit_valid, max_height_mm);
				end
			end
		end
	end

	initial begin
		window_len = 24'd1000000;
		min_span = 24'd200000;
		model_clear();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_settings();
		test_backpressure();
		test_idle_mix();
		drain();
		if (pending_fits.size() != 0) mismatches++;
		$display("Sent %0d items, checked %0d results, %0d of them line fits.",
			items_sent, fits_checked, fits_with_line);
		$display("Covered six window settings, long result stalls and mixed idling.");
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#40000000;
		$display("Timeout with %0d results outstanding", pending_fits.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
design/wvsf_pkg.sv
design/wvsf_mul.sv
design/wvsf_div.sv
design/windowed_vertical_speed_fit.sv
sim/windowed_vertical_speed_fit_test.sv
